// ===== rtl/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// shared types and constants of the dmx fade and refresh unit
// ----------------------------------------------------------------------------
package dfr_pkg;

  // field widths
  localparam int CMD_W  = 3;
  localparam int CH_W   = 6;
  localparam int LVL_W  = 8;
  localparam int ACT_W  = 2;
  localparam int STEP_W = 8;

  // default channel count and register reset
  localparam int                CHANNELS_DEF = 16;
  localparam logic [STEP_W-1:0] PERIOD_RST   = 8'd20;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_LEVEL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_TARGET = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd4;

  // refresh actions
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BREAK = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MAB   = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SLOT   = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [CH_W-1:0]  channel;
    logic [LVL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  slot;
    logic [LVL_W-1:0] level;
    logic [ACT_W-1:0] refresh_action;
    logic             accepted;
    logic             last;
  } out_item_t;

  // access request to one channel store
  typedef struct packed {
    logic             we;
    logic [CH_W-1:0]  waddr;
    logic [LVL_W-1:0] wdata;
    logic             re;
    logic [CH_W-1:0]  raddr;
    logic             clr;
  } store_req_t;

endpackage

// ===== rtl/dfr_store.sv =====
// ----------------------------------------------------------------------------
// dfr_store
// per-channel byte store: synchronous memory, one write and one read port,
// per-entry valid bits so that a clear makes every entry read as zero at once
// ----------------------------------------------------------------------------
module dfr_store #(
  parameter int DEPTH = dfr_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dfr_pkg::store_req_t         req,
  output logic [dfr_pkg::LVL_W-1:0]   rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [dfr_pkg::LVL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld_r;
  logic [dfr_pkg::LVL_W-1:0] rd_r;
  logic                      rd_vld_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rd_r <= mem[req.raddr[AW-1:0]];
    end
  end

  // entry valid bits, cleared by reset or a clear request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clr) begin
        vld_r <= '0;
      end else if (req.we) begin
        vld_r[req.waddr[AW-1:0]] <= 1'b1;
      end
      if (req.re) begin
        rd_vld_r <= vld_r[req.raddr[AW-1:0]];
      end
    end
  end

  // entries never written since the last clear read as zero
  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

// ===== rtl/dfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfr_ctrl
// command sequencer: decodes items, runs the fade pass as a read-modify-write
// sweep over the stores, keeps the refresh counter and drives the result
// register
// ----------------------------------------------------------------------------
module dfr_ctrl #(
  parameter int CHANNELS = dfr_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dfr_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dfr_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [dfr_pkg::STEP_W-1:0]    cfg_wdata,
  output dfr_pkg::store_req_t           lvl_req,
  output dfr_pkg::store_req_t           tgt_req,
  input  logic [dfr_pkg::LVL_W-1:0]     lvl_rdata,
  input  logic [dfr_pkg::LVL_W-1:0]     tgt_rdata
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(CHANNELS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STAT  = 3'd1;
  localparam logic [2:0] S_SLOT0 = 3'd2;
  localparam logic [2:0] S_FRD   = 3'd3;
  localparam logic [2:0] S_FWR   = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [dfr_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [dfr_pkg::STEP_W-1:0]  period_r, period_nxt;
  logic                        run_r, run_nxt;
  logic [dfr_pkg::ACT_W-1:0]   act_r, act_nxt;
  logic                        acc_r, acc_nxt;
  logic                        fade_r, fade_nxt;
  logic                        frame_r, frame_nxt;
  dfr_pkg::out_item_t          out_r, out_nxt;
  logic                        out_vld_r, out_vld_nxt;

  logic                        in_acc;
  logic                        can_push;
  logic                        in_range;
  logic [dfr_pkg::STEP_W-1:0]  step_inc;
  logic [dfr_pkg::CH_W-1:0]    ch_addr;
  logic [dfr_pkg::LVL_W-1:0]   faded;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign can_push  = !out_vld_r || !out_stall;
  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  assign in_range = (in_item.channel != '0) &&
                    (in_item.channel <= dfr_pkg::CH_W'(CHANNELS));
  assign ch_addr  = in_item.channel - dfr_pkg::CH_W'(1);
  assign step_inc = step_r + dfr_pkg::STEP_W'(1);

  // one fade step toward the target
  always_comb begin
    if (lvl_rdata < tgt_rdata) begin
      faded = lvl_rdata + dfr_pkg::LVL_W'(1);
    end else if (lvl_rdata > tgt_rdata) begin
      faded = lvl_rdata - dfr_pkg::LVL_W'(1);
    end else begin
      faded = lvl_rdata;
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    step_nxt    = step_r;
    period_nxt  = cfg_we ? cfg_wdata : period_r;
    run_nxt     = run_r;
    act_nxt     = act_r;
    acc_nxt     = acc_r;
    fade_nxt    = fade_r;
    frame_nxt   = frame_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && out_stall;
    lvl_req     = '0;
    tgt_req     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_nxt   = dfr_pkg::ACT_NONE;
          acc_nxt   = 1'b0;
          fade_nxt  = 1'b0;
          frame_nxt = 1'b0;
          case (in_item.command)
            dfr_pkg::CMD_TICK: begin
              if (run_r) begin
                fade_nxt = 1'b1;
                step_nxt = step_inc;
                if (step_inc == dfr_pkg::STEP_W'(1)) begin
                  act_nxt = dfr_pkg::ACT_BREAK;
                end else if (step_inc == dfr_pkg::STEP_W'(2)) begin
                  act_nxt   = dfr_pkg::ACT_MAB;
                  frame_nxt = 1'b1;
                end else if (step_inc > period_r) begin
                  step_nxt = '0;
                end
              end
            end
            dfr_pkg::CMD_SET_LEVEL: begin
              acc_nxt       = in_range;
              lvl_req.we    = in_range;
              lvl_req.waddr = ch_addr;
              lvl_req.wdata = in_item.value;
            end
            dfr_pkg::CMD_SET_TARGET: begin
              acc_nxt       = in_range;
              tgt_req.we    = in_range;
              tgt_req.waddr = ch_addr;
              tgt_req.wdata = in_item.value;
            end
            dfr_pkg::CMD_START: begin
              lvl_req.clr = 1'b1;
              tgt_req.clr = 1'b1;
              step_nxt    = '0;
              run_nxt     = 1'b1;
            end
            dfr_pkg::CMD_STOP: begin
              run_nxt = 1'b0;
            end
            default: begin
            end
          endcase
          state_nxt = S_STAT;
        end
      end

      // status result first
      S_STAT: begin
        if (can_push) begin
          out_vld_nxt            = 1'b1;
          out_nxt.kind           = dfr_pkg::KIND_STATUS;
          out_nxt.slot           = '0;
          out_nxt.level          = '0;
          out_nxt.refresh_action = act_r;
          out_nxt.accepted       = acc_r;
          out_nxt.last           = !frame_r;
          idx_nxt                = '0;
          if (frame_r) begin
            state_nxt = S_SLOT0;
          end else if (fade_r) begin
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      // control byte slot
      S_SLOT0: begin
        if (can_push) begin
          out_vld_nxt            = 1'b1;
          out_nxt.kind           = dfr_pkg::KIND_SLOT;
          out_nxt.slot           = '0;
          out_nxt.level          = '0;
          out_nxt.refresh_action = dfr_pkg::ACT_NONE;
          out_nxt.accepted       = 1'b0;
          out_nxt.last           = 1'b0;
          state_nxt              = S_FRD;
        end
      end

      // read level and target of one channel
      S_FRD: begin
        lvl_req.re    = 1'b1;
        lvl_req.raddr = dfr_pkg::CH_W'(idx_r);
        tgt_req.re    = 1'b1;
        tgt_req.raddr = dfr_pkg::CH_W'(idx_r);
        state_nxt     = S_FWR;
      end

      // write back the faded level, send it as a slot when framing
      S_FWR: begin
        if (!frame_r || can_push) begin
          lvl_req.we    = 1'b1;
          lvl_req.waddr = dfr_pkg::CH_W'(idx_r);
          lvl_req.wdata = faded;
          if (frame_r) begin
            out_vld_nxt            = 1'b1;
            out_nxt.kind           = dfr_pkg::KIND_SLOT;
            out_nxt.slot           = dfr_pkg::CH_W'(idx_r) + dfr_pkg::CH_W'(1);
            out_nxt.level          = faded;
            out_nxt.refresh_action = dfr_pkg::ACT_NONE;
            out_nxt.accepted       = 1'b0;
            out_nxt.last           = (idx_r == IDX_LAST);
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_FRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      step_r    <= '0;
      period_r  <= dfr_pkg::PERIOD_RST;
      run_r     <= 1'b0;
      out_vld_r <= 1'b0;
      fade_r    <= 1'b0;
      frame_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      step_r    <= step_nxt;
      period_r  <= period_nxt;
      run_r     <= run_nxt;
      out_vld_r <= out_vld_nxt;
      fade_r    <= fade_nxt;
      frame_r   <= frame_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    acc_r <= acc_nxt;
    out_r <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  // a write-back always follows the read of the same channel
  a_read_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FWR |-> $past(state_r) == S_FRD || $past(state_r) == S_FWR)
    else $error("fade write-back without a preceding read");

  // the level store is never read and written in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(lvl_req.we && lvl_req.re))
    else $error("level store read and write overlap");

  // a fade sweep only runs for a tick taken while running
  a_fade_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FRD |-> fade_r)
    else $error("fade sweep without a running tick");

  // frame slot results carry no status
  a_slot_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.kind == dfr_pkg::KIND_SLOT |->
      out_r.refresh_action == dfr_pkg::ACT_NONE && !out_r.accepted)
    else $error("frame slot result with status fields set");

  // the refresh counter only moves when an item is taken
  a_step_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !in_acc |=> $stable(step_r))
    else $error("refresh counter moved without an item");
`endif

endmodule

// ===== rtl/dmx_fade_and_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// dmx_fade_and_refresh_unit
// dmx level store with per-channel fade targets and refresh sequencing
// ----------------------------------------------------------------------------
// items: one at a time; in_stall is high outside the idle state, so the next item
//   is taken only once the last one is through. Each item gives a registered status
//   result; a running tick adds a fade sweep (one store read and one write-back per
//   channel), preceded by the control byte slot when it sends a frame
// reset: stopped, counter 0, period 20, all levels and targets read as zero
//   at once (valid bits), no clearing pass
module dmx_fade_and_refresh_unit #(
  parameter int CHANNELS = dfr_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  dfr_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dfr_pkg::out_item_t          out_item,
  input  logic                        cfg_we,
  input  logic [dfr_pkg::STEP_W-1:0]  cfg_wdata
);

  dfr_pkg::store_req_t        lvl_req;
  dfr_pkg::store_req_t        tgt_req;
  logic [dfr_pkg::LVL_W-1:0]  lvl_rdata;
  logic [dfr_pkg::LVL_W-1:0]  tgt_rdata;

  // sequencer
  dfr_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .lvl_req   (lvl_req),
    .tgt_req   (tgt_req),
    .lvl_rdata (lvl_rdata),
    .tgt_rdata (tgt_rdata)
  );

  // channel levels
  dfr_store #(
    .DEPTH (CHANNELS)
  ) u_levels (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lvl_req),
    .rdata (lvl_rdata)
  );

  // fade targets
  dfr_store #(
    .DEPTH (CHANNELS)
  ) u_targets (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tgt_req),
    .rdata (tgt_rdata)
  );

endmodule
